### src/gsr_pkg.sv
// Shared types, codes and constants of the grouped scatter-reduce engine.
package gsr_pkg;

    localparam int CELL_W     = 48;
    localparam int VAL_W      = 32;
    localparam int SUB_W      = 16;
    localparam int DIM_W      = 11;
    localparam int OP_W       = 2;
    localparam int RED_W      = 3;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [CELL_W-1:0] cell_t;

    localparam logic [OP_W-1:0] OP_CONTRIB = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [RED_W-1:0] RED_SUM  = 3'd0;
    localparam logic [RED_W-1:0] RED_MEAN = 3'd1;
    localparam logic [RED_W-1:0] RED_PROD = 3'd2;
    localparam logic [RED_W-1:0] RED_MAX  = 3'd3;
    localparam logic [RED_W-1:0] RED_MIN  = 3'd4;
    localparam logic [RED_W-1:0] RED_ANY  = 3'd5;
    localparam logic [RED_W-1:0] RED_ALL  = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REDUCER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd3;

    localparam cell_t CELL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam cell_t CELL_MIN = 48'sh8000_0000_0000;
    localparam cell_t Q_ONE    = 48'sd65536;

    // memory strobes from the sequencer to the store
    typedef struct packed {
        logic rd_en;
        logic cell_we;
        logic touch_we;
        logic touch_val;
    } mem_ctl_t;

    function automatic cell_t identity(input logic [RED_W-1:0] red);
        cell_t id;
        case (red)
            RED_PROD, RED_ALL: id = Q_ONE;
            RED_MAX:           id = CELL_MIN;
            RED_MIN:           id = CELL_MAX;
            default:           id = '0;
        endcase
        return id;
    endfunction

endpackage

### src/gsr_store.sv
// Cell/count memory and touched-bit memory, with registered reads.
module gsr_store #(
    parameter int CELLS      = 1024,
    parameter int COUNT_BITS = 24,
    localparam int AW        = $clog2(CELLS)
) (
    input  logic                      aclk,
    input  gsr_pkg::mem_ctl_t         ctl,
    input  logic [AW-1:0]             rd_addr,
    input  logic [AW-1:0]             wr_addr,
    input  logic [AW-1:0]             touch_addr,
    input  gsr_pkg::cell_t            cell_wdata,
    input  logic [COUNT_BITS-1:0]     cnt_wdata,
    output gsr_pkg::cell_t            rd_cell,
    output logic [COUNT_BITS-1:0]     rd_count,
    output logic                      rd_touched
);
    import gsr_pkg::*;

    localparam int DW = CELL_W + COUNT_BITS;

    logic [DW-1:0] data_mem [CELLS];
    logic          touch_mem [CELLS];
    logic [DW-1:0] data_rd_reg;
    logic          touch_rd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.cell_we) begin
            data_mem[wr_addr] <= {cnt_wdata, cell_wdata};
        end
        if (ctl.rd_en) begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.touch_we) begin
            touch_mem[touch_addr] <= ctl.touch_val;
        end
        if (ctl.rd_en) begin
            touch_rd_reg <= touch_mem[rd_addr];
        end
    end

    assign rd_cell    = data_rd_reg[CELL_W-1:0];
    assign rd_count   = data_rd_reg[DW-1:CELL_W];
    assign rd_touched = touch_rd_reg;

endmodule

### src/gsr_mul.sv
// Q32.16 x Q16.16 product with saturation, one 24x32 multiplier over two passes.
module gsr_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  gsr_pkg::cell_t        acc,
    input  logic signed [31:0]    value,
    output logic                  done,
    output gsr_pkg::cell_t        result,
    output logic                  sat
);
    import gsr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    logic [47:0] ma_reg;
    logic [31:0] mb_reg;
    logic        neg_reg;
    logic [55:0] plo_reg, phi_reg;
    cell_t       res_reg;
    logic        sat_reg;

    logic [23:0] mul_a;
    logic [55:0] prod;
    logic [79:0] full;
    logic [63:0] mag;

    assign mul_a = (phase_reg == PH_LO) ? ma_reg[23:0] : ma_reg[47:24];
    assign prod  = {32'd0, mul_a} * {24'd0, mb_reg};
    assign full  = {phi_reg, 24'd0} + {24'd0, plo_reg};
    // drop 16 fraction bits: truncation of the magnitude is toward zero
    assign mag   = full[79:16];

    always_comb begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE: if (start) phase_next = PH_LO;
            PH_LO:   phase_next = PH_HI;
            PH_HI:   phase_next = PH_FIN;
            PH_FIN: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    ma_reg  <= acc[47] ? 48'(-acc) : acc;
                    mb_reg  <= value[31] ? 32'(-value) : value;
                    neg_reg <= acc[47] ^ value[31];
                end
            end
            PH_LO: plo_reg <= prod;
            PH_HI: phi_reg <= prod;
            PH_FIN: begin
                if (neg_reg) begin
                    if (mag > 64'h0000_8000_0000_0000) begin
                        res_reg <= CELL_MIN;
                        sat_reg <= 1'b1;
                    end else begin
                        res_reg <= 48'(-mag);
                        sat_reg <= 1'b0;
                    end
                end else begin
                    if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
                        res_reg <= CELL_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        res_reg <= mag[47:0];
                        sat_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign sat    = sat_reg;

endmodule

### src/gsr_div.sv
// Restoring divider for the mean readout, one quotient bit a cycle.
module gsr_div #(
    parameter int DW = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  gsr_pkg::cell_t    dividend,
    input  logic [DW-1:0]     divisor,
    output logic              done,
    output gsr_pkg::cell_t    quotient
);
    import gsr_pkg::*;

    localparam int CW = $clog2(CELL_W + 1);
    localparam logic [CW-1:0] LAST = CW'(CELL_W - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [47:0]   a_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic          neg_reg;

    logic [DW:0]   shifted, diff;
    logic          ge;

    assign shifted = {rem_reg, a_reg[47]};
    assign diff    = shifted - {1'b0, d_reg};
    assign ge      = !diff[DW];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            a_reg   <= {a_reg[46:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end else if (start) begin
            a_reg   <= dividend[47] ? 48'(-dividend) : dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
            neg_reg <= dividend[47];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 48'(-a_reg) : a_reg;

endmodule

### src/grouped_scatter_reduce.sv
// Top level: sequencer, configuration registers and result register of the scatter-reduce engine.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//  s        in         s_valid/s_ready       s_operation, s_row_sub, s_col_sub, s_value
//  m        out        m_valid/m_ready       m_status, m_cell_result, m_was_touched
//
// Contribute and plain read pass through the accept, address, memory read and result states.
// Product contribute adds the two-pass multiplier; mean read adds the divider.
// Clear sweeps the touched memory; after reset the same sweep runs with s_ready low.
// Synchronous active-low reset.
// A new transaction is taken while the previous result waits; the block stalls in its
// last cycle only if the result register is still full.
module grouped_scatter_reduce #(
    parameter int CELLS      = 1024,
    parameter int COUNT_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gsr_pkg::OP_W-1:0]           s_operation,
    input  logic [gsr_pkg::SUB_W-1:0]          s_row_sub,
    input  logic [gsr_pkg::SUB_W-1:0]          s_col_sub,
    input  logic signed [gsr_pkg::VAL_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gsr_pkg::ST_W-1:0]           m_status,
    output logic signed [gsr_pkg::CELL_W-1:0]  m_cell_result,
    output logic                               m_was_touched
);
    import gsr_pkg::*;

    localparam int AW    = $clog2(CELLS);
    localparam int LIN_W = 2 * DIM_W;
    localparam logic [AW-1:0]         SWEEP_LAST = AW'(CELLS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                m_valid_reg, m_valid_next;

    logic [RED_W-1:0]    reducer_reg;
    logic signed [31:0]  fill_reg;
    logic [DIM_W-1:0]    rows_reg, cols_reg;

    logic [OP_W-1:0]     op_reg;
    logic [SUB_W-1:0]    row_reg, col_reg;
    logic signed [31:0]  val_reg;
    logic [LIN_W-1:0]    lin_reg;

    logic [ST_W-1:0]     res_status_reg;
    cell_t               res_cell_reg;
    logic                res_touched_reg;
    logic [ST_W-1:0]     m_status_reg;
    cell_t               m_cell_reg;
    logic                m_touched_reg;

    logic [SUB_W-1:0]    row_m1, col_m1;
    logic [LIN_W-1:0]    lin;
    logic                good;
    logic                is_access;
    logic                sweeping, last_sweep, out_free;

    mem_ctl_t            mem_ctl;
    cell_t               rd_cell;
    logic [COUNT_BITS-1:0] rd_count, cnt_new;
    logic                rd_touched;
    logic                cnt_sat;

    cell_t               acc, v_ext, fold_val, wr_cell;
    logic [48:0]         sum49;
    logic                fold_sat;

    logic                mul_start, mul_done, mul_sat;
    cell_t               mul_res;
    logic                div_start, div_done;
    cell_t               div_q;

    // ---- configuration ----
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reducer_reg <= RED_SUM;
            fill_reg    <= '0;
            rows_reg    <= 11'd1024;
            cols_reg    <= 11'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_REDUCER: reducer_reg <= cfg_data[RED_W-1:0];
                CFG_FILL:    fill_reg    <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data[DIM_W-1:0];
                CFG_COLS:    cols_reg    <= cfg_data[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---- address check, column-major index ----
    assign row_m1 = row_reg - 1'b1;
    assign col_m1 = col_reg - 1'b1;
    assign lin    = {{DIM_W{1'b0}}, row_m1[DIM_W-1:0]}
                  + ({{DIM_W{1'b0}}, col_m1[DIM_W-1:0]} * {{DIM_W{1'b0}}, rows_reg});
    assign good   = (row_reg != '0) && (col_reg != '0)
                  && (row_reg <= {{(SUB_W-DIM_W){1'b0}}, rows_reg})
                  && (col_reg <= {{(SUB_W-DIM_W){1'b0}}, cols_reg})
                  && (lin < LIN_W'(CELLS));
    assign is_access = (op_reg == OP_CONTRIB) || (op_reg == OP_READ);

    // ---- fold ----
    assign v_ext = {{(CELL_W-32){val_reg[31]}}, val_reg};
    assign acc   = rd_touched ? rd_cell : identity(reducer_reg);
    assign sum49 = {acc[47], acc} + {v_ext[47], v_ext};

    always_comb begin
        fold_sat = 1'b0;
        case (reducer_reg)
            RED_MAX: fold_val = (v_ext > acc) ? v_ext : acc;
            RED_MIN: fold_val = (v_ext < acc) ? v_ext : acc;
            RED_ANY: fold_val = ((acc != '0) || (v_ext != '0)) ? Q_ONE : '0;
            RED_ALL: fold_val = ((acc != '0) && (v_ext != '0)) ? Q_ONE : '0;
            default: begin
                if (sum49[48] != sum49[47]) begin
                    fold_sat = 1'b1;
                    fold_val = sum49[48] ? CELL_MIN : CELL_MAX;
                end else begin
                    fold_val = sum49[47:0];
                end
            end
        endcase
    end

    // count saturates; only mean cares that a hit went uncounted
    assign cnt_new = !rd_touched ? COUNT_BITS'(1)
                   : (rd_count != CNT_MAX) ? rd_count + 1'b1 : rd_count;
    assign cnt_sat = rd_touched && (rd_count == CNT_MAX) && (reducer_reg == RED_MEAN);

    assign wr_cell = (state_reg == S_MUL) ? mul_res : fold_val;

    // ---- sequencer ----
    assign sweeping   = (state_reg == S_INIT) || (state_reg == S_CLEAR);
    assign last_sweep = sweep_reg == SWEEP_LAST;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = state_reg == S_IDLE;

    assign mul_start = (state_reg == S_READ) && (op_reg == OP_CONTRIB)
                     && (reducer_reg == RED_PROD);
    assign div_start = (state_reg == S_READ) && (op_reg == OP_READ) && rd_touched
                     && (reducer_reg == RED_MEAN) && (rd_count != '0);

    always_comb begin
        mem_ctl.rd_en     = (state_reg == S_ADDR) && good && is_access;
        mem_ctl.cell_we   = ((state_reg == S_READ) && (op_reg == OP_CONTRIB)
                             && (reducer_reg != RED_PROD))
                          || ((state_reg == S_MUL) && mul_done);
        mem_ctl.touch_we  = mem_ctl.cell_we || sweeping;
        mem_ctl.touch_val = !sweeping;
    end

    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_INIT, S_CLEAR: begin
                sweep_next = last_sweep ? '0 : sweep_reg + 1'b1;
                if (last_sweep) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: if (s_valid) state_next = S_ADDR;
            S_ADDR: begin
                if (op_reg == OP_CLEAR) begin
                    state_next = S_CLEAR;
                end else if (!is_access || !good) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (mul_start) begin
                    state_next = S_MUL;
                end else if (div_start) begin
                    state_next = S_DIV;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MUL: if (mul_done) state_next = S_DONE;
            S_DIV: if (div_done) state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---- transaction and result payload ----
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_reg  <= s_operation;
                    row_reg <= s_row_sub;
                    col_reg <= s_col_sub;
                    val_reg <= s_value;
                end
            end
            S_ADDR: begin
                lin_reg         <= lin;
                res_status_reg  <= (is_access && !good) ? ST_RANGE : ST_OK;
                res_cell_reg    <= '0;
                res_touched_reg <= 1'b0;
            end
            S_READ: begin
                if (op_reg == OP_CONTRIB) begin
                    res_status_reg  <= (fold_sat || cnt_sat) ? ST_SAT : ST_OK;
                    res_touched_reg <= 1'b1;
                end else begin
                    res_touched_reg <= rd_touched;
                    res_cell_reg    <= rd_touched ? rd_cell
                                     : {{(CELL_W-32){fill_reg[31]}}, fill_reg};
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    res_status_reg <= (mul_sat || cnt_sat) ? ST_SAT : ST_OK;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    res_cell_reg <= div_q;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_status_reg  <= res_status_reg;
                    m_cell_reg    <= res_cell_reg;
                    m_touched_reg <= res_touched_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_cell_result = m_cell_reg;
    assign m_was_touched = m_touched_reg;

    // ---- units ----
    gsr_store #(
        .CELLS      (CELLS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .aclk       (aclk),
        .ctl        (mem_ctl),
        .rd_addr    (lin[AW-1:0]),
        .wr_addr    (lin_reg[AW-1:0]),
        .touch_addr (sweeping ? sweep_reg : lin_reg[AW-1:0]),
        .cell_wdata (wr_cell),
        .cnt_wdata  (cnt_new),
        .rd_cell    (rd_cell),
        .rd_count   (rd_count),
        .rd_touched (rd_touched)
    );

    gsr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .acc     (acc),
        .value   (val_reg),
        .done    (mul_done),
        .result  (mul_res),
        .sat     (mul_sat)
    );

    gsr_div #(
        .DW (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rd_cell),
        .divisor  (rd_count),
        .done     (div_done),
        .quotient (div_q)
    );

`ifndef SYNTH
    a_write_only_contrib: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.cell_we |-> op_reg == OP_CONTRIB)
        else $error("cell write outside a contribute transaction");

    a_div_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == S_DIV)
        else $error("divider started without entering divide state");

    a_clear_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADDR && op_reg == OP_CLEAR) |=> sweep_reg == '0)
        else $error("clear sweep does not start at entry zero");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the done state");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for grouped_scatter_reduce: directed table, then randomised phases.
module tb_top;
    import gsr_pkg::*;

    localparam int CELLS      = 1024;
    localparam int COUNT_BITS = 24;
    localparam int unsigned HIT_MAX = (1 << COUNT_BITS) - 1;
    localparam int WDOG_LIMIT = 20000;
    localparam logic [OP_W-1:0]  OP_RSVD   = 2'd3;
    localparam logic [RED_W-1:0] RED_ALIAS = 3'd7;   // spare code, folds as sum

    typedef struct {
        logic [ST_W-1:0] status;
        cell_t           cell_val;
        logic            touched;
    } cell_res_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [SUB_W-1:0] row;
        logic [SUB_W-1:0] col;
        logic [VAL_W-1:0] val;
        bit               typed;
        cell_res_t        res;
    } stim_row_t;

    typedef struct {
        logic [RED_W-1:0] red;
        logic [VAL_W-1:0] fill;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        bit               clear_first;
    } phase_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = '0;
    logic [SUB_W-1:0] s_row_sub = '0;
    logic [SUB_W-1:0] s_col_sub = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ST_W-1:0] m_status;
    logic signed [CELL_W-1:0] m_cell_result;
    logic m_was_touched;

    always #5 aclk = ~aclk;

    grouped_scatter_reduce #(.CELLS(CELLS), .COUNT_BITS(COUNT_BITS)) i_dut (.*);

    // predictor state
    longint      cell_mem [CELLS];
    bit          touch_mem [CELLS];
    int unsigned hit_mem [CELLS];
    logic [RED_W-1:0]        red_cfg  = RED_SUM;
    logic signed [VAL_W-1:0] fill_cfg = '0;
    logic [DIM_W-1:0]        rows_cfg = 11'd1024;
    logic [DIM_W-1:0]        cols_cfg = 11'd1;

    cell_res_t pending_q [$];
    bit        cur_typed = 1'b0;
    cell_res_t cur_res;
    int errors = 0;
    int n_contrib = 0, n_read = 0, n_range = 0, n_sat = 0, n_clear = 0, n_out = 0;
    int burst_left = 0;

    function automatic longint clamp_cell(input longint x, inout bit sat);
        if (x > longint'(CELL_MAX)) begin
            sat = 1'b1;
            return longint'(CELL_MAX);
        end
        if (x < longint'(CELL_MIN)) begin
            sat = 1'b1;
            return longint'(CELL_MIN);
        end
        return x;
    endfunction

    // Q32.16 x Q16.16, magnitude truncated toward zero
    function automatic longint mul_fixed(input longint a, input longint b, inout bit sat);
        bit neg;
        longint unsigned ma, mb, mag;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : a;
        mb  = (b < 0) ? longint'(-b) : b;
        mag = ma * (mb >> 16) + ((ma * (mb & 64'hFFFF)) >> 16);
        if (neg) begin
            if (mag > (64'd1 << 47)) begin
                sat = 1'b1;
                return longint'(CELL_MIN);
            end
            return -longint'(mag);
        end
        if (mag > longint'(CELL_MAX)) begin
            sat = 1'b1;
            return longint'(CELL_MAX);
        end
        return longint'(mag);
    endfunction

    function automatic longint fold_cell(input logic [RED_W-1:0] red, input longint acc,
                                         input longint v, inout bit sat);
        case (red)
            RED_PROD: return mul_fixed(acc, v, sat);
            RED_MAX:  return (v > acc) ? v : acc;
            RED_MIN:  return (v < acc) ? v : acc;
            RED_ANY:  return (acc != 0 || v != 0) ? longint'(Q_ONE) : 0;
            RED_ALL:  return (acc != 0 && v != 0) ? longint'(Q_ONE) : 0;
            default:  return clamp_cell(acc + v, sat);
        endcase
    endfunction

    function automatic longint seed_value(input logic [RED_W-1:0] red);
        case (red)
            RED_PROD, RED_ALL: return longint'(Q_ONE);
            RED_MAX:           return longint'(CELL_MIN);
            RED_MIN:           return longint'(CELL_MAX);
            default:           return 0;
        endcase
    endfunction

    function automatic cell_res_t predict_cell(input logic [OP_W-1:0] op,
                                               input logic [SUB_W-1:0] r,
                                               input logic [SUB_W-1:0] c,
                                               input logic signed [VAL_W-1:0] v);
        cell_res_t o;
        int unsigned lin;
        bit good, sat;
        o.status = ST_OK;
        o.cell_val = '0;
        o.touched = 1'b0;
        lin = 0;
        sat = 1'b0;
        if (op == OP_CLEAR) begin
            foreach (touch_mem[i]) touch_mem[i] = 1'b0;
            return o;
        end
        if (op == OP_RSVD) return o;
        good = r >= 1 && c >= 1 && r <= rows_cfg && c <= cols_cfg;
        if (good) begin
            lin = (int'(r) - 1) + (int'(c) - 1) * int'(rows_cfg);
            good = lin < CELLS;
        end
        if (!good) begin
            o.status = ST_RANGE;
            return o;
        end
        if (op == OP_CONTRIB) begin
            if (!touch_mem[lin]) begin
                cell_mem[lin] = fold_cell(red_cfg, seed_value(red_cfg), longint'(v), sat);
                touch_mem[lin] = 1'b1;
                hit_mem[lin] = 1;
            end else begin
                cell_mem[lin] = fold_cell(red_cfg, cell_mem[lin], longint'(v), sat);
                if (hit_mem[lin] < HIT_MAX) hit_mem[lin]++;
                else if (red_cfg == RED_MEAN) sat = 1'b1;
            end
            o.status = sat ? ST_SAT : ST_OK;
            o.touched = 1'b1;
        end else begin
            o.touched = touch_mem[lin];
            if (!touch_mem[lin]) o.cell_val = fill_cfg;
            else if (red_cfg == RED_MEAN && hit_mem[lin] != 0)
                o.cell_val = cell_t'(cell_mem[lin] / longint'(hit_mem[lin]));
            else o.cell_val = cell_t'(cell_mem[lin]);
        end
        return o;
    endfunction

    // acceptance monitor: config, inputs, results
    always @(posedge aclk) begin
        cell_res_t e;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REDUCER: red_cfg  <= cfg_data[RED_W-1:0];
                    CFG_FILL:    fill_cfg <= cfg_data;
                    CFG_ROWS:    rows_cfg <= cfg_data[DIM_W-1:0];
                    default:     cols_cfg <= cfg_data[DIM_W-1:0];
                endcase
            end
            if (s_valid && s_ready) begin
                e = predict_cell(s_operation, s_row_sub, s_col_sub, s_value);
                if (cur_typed) e = cur_res;
                pending_q.push_back(e);
                case (s_operation)
                    OP_CONTRIB: n_contrib++;
                    OP_READ:    n_read++;
                    OP_CLEAR:   n_clear++;
                    default:    ;
                endcase
                if (e.status == ST_RANGE) n_range++;
                if (e.status == ST_SAT) n_sat++;
            end
            if (m_valid && m_ready) begin
                n_out++;
                if (pending_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    e = pending_q.pop_front();
                    if (m_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, m_status);
                        errors++;
                    end
                    if (m_cell_result !== e.cell_val) begin
                        $error("cell_result: expected %0d, got %0d", e.cell_val,
                               m_cell_result);
                        errors++;
                    end
                    if (m_was_touched !== e.touched) begin
                        $error("was_touched: expected %0d, got %0d", e.touched, m_was_touched);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver back-pressure: stall density changes whenever its age counter runs out
    int stall_pct = 0;
    int stall_age = 0;
    always @(negedge aclk) begin
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_age = $urandom_range(50, 300);
        end
        stall_age--;
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("grouped_scatter_reduce verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [SUB_W-1:0] r,
                             input logic [SUB_W-1:0] c, input logic [VAL_W-1:0] v,
                             input bit typed, input cell_res_t res);
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_row_sub   <= r;
        s_col_sub   <= c;
        s_value     <= v;
        cur_typed   <= typed;
        cur_res     <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // back-to-back register writes; caller drops valid with cfg_release
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic cfg_release;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value;
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2, 3: return ($urandom_range(0, 1) ? 32'd1 : -32'sd1) * ($urandom_range(1, 4) << 16);
            4:    return 32'h7FFF_FFFF;
            5:    return 32'h8000_0000;
            6:    return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [SUB_W-1:0] pick_sub(input logic [DIM_W-1:0] lim);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return SUB_W'($urandom());
        if (k == 1) return 16'd0;
        if (k == 2) return SUB_W'(lim) + SUB_W'($urandom_range(1, 3));
        if (lim == 0) return SUB_W'($urandom_range(1, 3));
        if (k < 14) return SUB_W'($urandom_range(1, (lim < 6) ? lim : 6));
        return SUB_W'($urandom_range(1, lim));
    endfunction

    cell_res_t no_res = '{ST_OK, '0, 1'b0};

    stim_row_t directed [] = '{
        '{OP_READ,    16'd1,     16'd1,     32'd0,         1'b1, '{ST_OK, '0, 1'b0}},
        '{OP_CONTRIB, 16'd1,     16'd1,     32'h7FFF_FFFF, 1'b1, '{ST_OK, '0, 1'b1}},
        '{OP_CONTRIB, 16'd1024,  16'd1,     32'h8000_0000, 1'b1, '{ST_OK, '0, 1'b1}},
        '{OP_READ,    16'd1,     16'd1,     32'd0,         1'b1,
          '{ST_OK, 48'sh0000_7FFF_FFFF, 1'b1}},
        '{OP_READ,    16'd1024,  16'd1,     32'd0,         1'b1,
          '{ST_OK, 48'shFFFF_8000_0000, 1'b1}},
        '{OP_CONTRIB, 16'd0,     16'd1,     32'd5,         1'b1, '{ST_RANGE, '0, 1'b0}},
        '{OP_READ,    16'd1,     16'd0,     32'd0,         1'b1, '{ST_RANGE, '0, 1'b0}},
        '{OP_CONTRIB, 16'd1025,  16'd1,     32'd1,         1'b1, '{ST_RANGE, '0, 1'b0}},
        '{OP_READ,    16'd1,     16'd2,     32'd0,         1'b1, '{ST_RANGE, '0, 1'b0}},
        '{OP_CONTRIB, 16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF, 1'b1, '{ST_RANGE, '0, 1'b0}},
        '{OP_RSVD,    16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF, 1'b1, '{ST_OK, '0, 1'b0}},
        '{OP_CONTRIB, 16'd1,     16'd1,     32'd1,         1'b0, '{ST_OK, '0, 1'b0}},
        '{OP_READ,    16'd1,     16'd1,     32'd0,         1'b0, '{ST_OK, '0, 1'b0}},
        '{OP_CLEAR,   16'd3,     16'd7,     32'd9,         1'b1, '{ST_OK, '0, 1'b0}},
        '{OP_READ,    16'd1,     16'd1,     32'd0,         1'b1, '{ST_OK, '0, 1'b0}},
        '{OP_CONTRIB, 16'd512,   16'd1,     32'hFFFF_FFFF, 1'b0, '{ST_OK, '0, 1'b0}},
        '{OP_CONTRIB, 16'd512,   16'd1,     32'h0003_0000, 1'b0, '{ST_OK, '0, 1'b0}},
        '{OP_READ,    16'd512,   16'd1,     32'd0,         1'b0, '{ST_OK, '0, 1'b0}}
    };

    phase_t phases [] = '{
        '{RED_SUM,   32'h0001_8000, 11'd1024, 11'd1,    1'b1},
        '{RED_MEAN,  32'hFFFE_0000, 11'd32,   11'd32,   1'b1},
        '{RED_PROD,  32'h0000_0001, 11'd8,    11'd4,    1'b1},
        '{RED_ALIAS, 32'h1234_5678, 11'd8,    11'd4,    1'b0},
        '{RED_MAX,   32'h8000_0000, 11'd1,    11'd1024, 1'b1},
        '{RED_MIN,   32'h7FFF_FFFF, 11'd16,   11'd16,   1'b1},
        '{RED_ANY,   32'h0000_0000, 11'd4,    11'd4,    1'b1},
        '{RED_ALL,   32'hFFFF_FFFF, 11'd4,    11'd4,    1'b0},
        '{RED_MEAN,  32'h0000_0000, 11'd4,    11'd4,    1'b0},
        '{RED_PROD,  32'h0005_0000, 11'd2047, 11'd2047, 1'b1},
        '{RED_SUM,   32'h8000_0000, 11'd1,    11'd1,    1'b1},
        '{RED_MEAN,  32'h7FFF_FFFF, 11'd0,    11'd5,    1'b1},
        '{RED_MAX,   32'h0000_0000, 11'd1024, 11'd1,    1'b1}
    };

    initial begin
        int per_phase, k;
        logic [OP_W-1:0] op;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].op, directed[i].row, directed[i].col, directed[i].val,
                      directed[i].typed, directed[i].res);

        per_phase = 1200 / phases.size();
        foreach (phases[p]) begin
            drain();
            cfg_write(CFG_REDUCER, CFG_DATA_W'(phases[p].red));
            cfg_write(CFG_FILL, phases[p].fill);
            cfg_write(CFG_ROWS, CFG_DATA_W'(phases[p].rows));
            cfg_write(CFG_COLS, CFG_DATA_W'(phases[p].cols));
            cfg_release();
            if (phases[p].clear_first)
                send_item(OP_CLEAR, SUB_W'($urandom()), SUB_W'($urandom()), $urandom(),
                          1'b0, no_res);
            for (int n = 0; n < per_phase; n++) begin
                k = $urandom_range(0, 99);
                if (k < 58) op = OP_CONTRIB;
                else if (k < 93) op = OP_READ;
                else if (k < 97) op = OP_CLEAR;
                else op = OP_RSVD;
                send_item(op, pick_sub(phases[p].rows), pick_sub(phases[p].cols),
                          pick_value(), 1'b0, no_res);
                // one mid-phase hold-off until every result is back
                if (p == 1 && n == per_phase / 2) drain();
            end
        end

        drain();
        $display("covered %0d contributes, %0d reads, %0d clears, %0d results over %0d phases",
                 n_contrib, n_read, n_clear, n_out, phases.size());
        $display("range errors predicted %0d, saturations predicted %0d", n_range, n_sat);
        if (errors == 0) $display("grouped_scatter_reduce verification clean");
        else $display("grouped_scatter_reduce verification failed");
        $finish;
    end

endmodule
